/* rtl/bresenham_line_pixel_stepper_assert.svh */
// Assertion macros for the Bresenham line pixel stepper.
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define BLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define BLS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BLS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/bls_pkg.sv */
// Shared types and constants of the Bresenham line pixel stepper.
`timescale 1ns / 1ps
`default_nettype none
package bls_pkg;

	localparam int COLOR_BITS = 16;
	localparam int CLIP_BITS  = 12;
	localparam int PITCH_BITS = 14;
	localparam int OFF_BITS   = 24;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [COLOR_BITS-1:0] START_COLOR = 16'hFFFF;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH   = 2'd2;

	localparam logic [CLIP_BITS-1:0]  CLIP_WIDTH_RST  = 12'd320;
	localparam logic [CLIP_BITS-1:0]  CLIP_HEIGHT_RST = 12'd240;
	localparam logic [PITCH_BITS-1:0] ROW_PITCH_RST   = 14'd640;

	// per-cycle control of the step stage
	typedef struct packed {
		logic accept;   // input transaction taken this cycle
		logic advance;  // step stage register loads this cycle
	} step_ctl_t;

endpackage
`default_nettype wire

/* rtl/bresenham_line_pixel_stepper.sv */
// Top level of the Bresenham line pixel stepper: config registers, pipeline control.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_stall   | cmd, x_start, y_start, x_end, y_end, pixel_color
//  out     | out_valid / out_stall | pix_x, pix_y, pix_color, byte_offset, visible, last
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction per clock unless in_stall; results pass stage 1, then stage 2.
// Stage 1 is the step unit (one add/compare update of the error term and position),
// stage 2 is the clip test and the y*pitch multiply for the byte offset.
// in_stall rises only when both stages hold results and out is stalled.
// Reset clears the line state (idle) and loads 320 x 240, pitch 640.
// cfg_ready is always high; writes are expected only while the pipe is empty.
`timescale 1ns / 1ps
`default_nettype none
`include "bresenham_line_pixel_stepper_assert.svh"
module bresenham_line_pixel_stepper import bls_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// input items
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    cmd,
	input  wire logic [COORD_BITS-1:0]   x_start,
	input  wire logic [COORD_BITS-1:0]   y_start,
	input  wire logic [COORD_BITS-1:0]   x_end,
	input  wire logic [COORD_BITS-1:0]   y_end,
	input  wire logic [COLOR_BITS-1:0]   pixel_color,
	// pixels
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [COORD_BITS-1:0]        pix_x,
	output logic [COORD_BITS-1:0]        pix_y,
	output logic [COLOR_BITS-1:0]        pix_color,
	output logic [OFF_BITS-1:0]          byte_offset,
	output logic                         visible,
	output logic                         last,
	// register writes
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [PITCH_BITS-1:0]   cfg_data
);

	logic [CLIP_BITS-1:0]  clip_width_q, clip_height_q;
	logic [PITCH_BITS-1:0] row_pitch_q;

	step_ctl_t                ctl;
	logic                     busy, valid_s1, last_s1;
	logic [COORD_BITS:0]      x_s1, y_s1;
	logic [COLOR_BITS-1:0]    color_s1;
	logic                     adv1, adv2;

	// Register writes; an index past the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_width_q  <= CLIP_WIDTH_RST;
			clip_height_q <= CLIP_HEIGHT_RST;
			row_pitch_q   <= ROW_PITCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLIP_WIDTH:  clip_width_q  <= cfg_data[CLIP_BITS-1:0];
				REG_CLIP_HEIGHT: clip_height_q <= cfg_data[CLIP_BITS-1:0];
				REG_ROW_PITCH:   row_pitch_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow: the result register loads when empty or drained,
	// stage 1 loads when empty or moving into stage 2.
	assign adv2        = !out_valid || !out_stall;
	assign adv1        = !valid_s1 || adv2;
	assign in_stall    = !adv1;
	assign ctl.accept  = in_valid && adv1;
	assign ctl.advance = adv1;

	bls_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.pixel_color(pixel_color),
		.busy       (busy),
		.valid_s1   (valid_s1),
		.x_s1       (x_s1),
		.y_s1       (y_s1),
		.color_s1   (color_s1),
		.last_s1    (last_s1)
	);

	bls_pix #(
		.COORD_BITS(COORD_BITS)
	) u_pix (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (adv2),
		.valid_s1       (valid_s1),
		.x_s1           (x_s1),
		.y_s1           (y_s1),
		.color_s1       (color_s1),
		.last_s1        (last_s1),
		.clip_width     (clip_width_q),
		.clip_height    (clip_height_q),
		.row_pitch_bytes(row_pitch_q),
		.out_valid      (out_valid),
		.pix_x          (pix_x),
		.pix_y          (pix_y),
		.pix_color      (pix_color),
		.byte_offset    (byte_offset),
		.visible        (visible),
		.last           (last)
	);

	// input back-pressure only when both stages are full and out is blocked
	`BLS_ASSERT_IMP(a_stall_only_full, clk, arst_n, in_stall, valid_s1 && out_valid && out_stall, "in_stall with room in the pipe")
	// every start command produces a pixel
	`BLS_ASSERT_NXT(a_start_emits, clk, arst_n, in_valid && !in_stall && (cmd == CMD_START), valid_s1, "start produced no pixel")
	// a step while idle produces nothing
	`BLS_ASSERT_NXT(a_idle_step_silent, clk, arst_n, in_valid && !in_stall && (cmd == CMD_STEP) && !busy, !valid_s1, "idle step produced a pixel")
	// a pixel in stage 1 moves on whenever the result register is free
	`BLS_ASSERT_NXT(a_s1_drains, clk, arst_n, valid_s1 && !(out_valid && out_stall), out_valid, "stage 1 pixel lost")

endmodule
`default_nettype wire

/* rtl/bls_step.sv */
// Line state and step logic; registers the next pixel position (stage 1).
`timescale 1ns / 1ps
`default_nettype none
module bls_step import bls_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire step_ctl_t             ctl,
	input  wire logic                  cmd,
	input  wire logic [COORD_BITS-1:0] x_start,
	input  wire logic [COORD_BITS-1:0] y_start,
	input  wire logic [COORD_BITS-1:0] x_end,
	input  wire logic [COORD_BITS-1:0] y_end,
	input  wire logic [COLOR_BITS-1:0] pixel_color,
	output logic                       busy,
	output logic                       valid_s1,
	output logic [COORD_BITS:0]        x_s1,
	output logic [COORD_BITS:0]        y_s1,
	output logic [COLOR_BITS-1:0]      color_s1,
	output logic                       last_s1
);

	localparam int XW = COORD_BITS + 1;  // position, one spare bit
	localparam int DW = COORD_BITS;      // absolute delta
	localparam int TW = COORD_BITS + 1;  // twice the delta
	localparam int EW = COORD_BITS + 3;  // error term, signed

	logic signed [XW-1:0] x1, y1, x2, y2;
	logic signed [XW-1:0] dx_raw, dy_raw;
	logic [DW-1:0]        dx, dy;
	logic                 sxn_n, syn_n, xm_n, last_init;
	logic [TW-1:0]        tdx_n, tdy_n;
	logic signed [EW-1:0] err_init;

	logic signed [XW-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [EW-1:0] err_q;
	logic [TW-1:0]        tdx_q, tdy_q;
	logic                 sxn_q, syn_q, xm_q, busy_q;
	logic [COLOR_BITS-1:0] line_color_q;

	logic signed [EW-1:0] tdx_e, tdy_e, err_nx;
	logic signed [XW-1:0] xinc, yinc, x_nx, y_nx;
	logic                 err_pos, err_zero, mv, last_nx, is_start;

	assign is_start = (cmd == CMD_START);

	// start setup
	assign x1 = {x_start[COORD_BITS-1], x_start};
	assign y1 = {y_start[COORD_BITS-1], y_start};
	assign x2 = {x_end[COORD_BITS-1], x_end};
	assign y2 = {y_end[COORD_BITS-1], y_end};

	assign sxn_n  = !(x2 > x1);
	assign syn_n  = !(y2 > y1);
	assign dx_raw = sxn_n ? (x1 - x2) : (x2 - x1);
	assign dy_raw = syn_n ? (y1 - y2) : (y2 - y1);
	assign dx     = dx_raw[DW-1:0];
	assign dy     = dy_raw[DW-1:0];
	assign tdx_n  = {dx, 1'b0};
	assign tdy_n  = {dy, 1'b0};
	assign xm_n   = (dx >= dy);

	assign err_init = xm_n
		? ($signed({{(EW-TW){1'b0}}, tdy_n}) - $signed({{(EW-DW){1'b0}}, dx}))
		: ($signed({{(EW-TW){1'b0}}, tdx_n}) - $signed({{(EW-DW){1'b0}}, dy}));
	assign last_init = xm_n ? (x1 == x2) : (y1 == y2);

	// one step along the major axis
	assign tdx_e    = $signed({{(EW-TW){1'b0}}, tdx_q});
	assign tdy_e    = $signed({{(EW-TW){1'b0}}, tdy_q});
	assign err_zero = (err_q == '0);
	assign err_pos  = !err_q[EW-1] && !err_zero;
	// ties move the minor axis only when the major axis steps up
	assign mv = err_pos || (err_zero && !(xm_q ? sxn_q : syn_q));

	assign xinc = sxn_q ? {XW{1'b1}} : XW'(1);
	assign yinc = syn_q ? {XW{1'b1}} : XW'(1);
	assign x_nx = (xm_q || mv) ? (cur_x_q + xinc) : cur_x_q;
	assign y_nx = (!xm_q || mv) ? (cur_y_q + yinc) : cur_y_q;
	assign err_nx = xm_q ? (err_q - (mv ? tdx_e : '0) + tdy_e)
	                     : (err_q - (mv ? tdy_e : '0) + tdx_e);
	assign last_nx = xm_q ? (x_nx == end_x_q) : (y_nx == end_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			err_q        <= '0;
			tdx_q        <= '0;
			tdy_q        <= '0;
			sxn_q        <= 1'b0;
			syn_q        <= 1'b0;
			xm_q         <= 1'b0;
			busy_q       <= 1'b0;
			line_color_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (ctl.accept) begin
				if (is_start) begin
					cur_x_q      <= x1;
					cur_y_q      <= y1;
					end_x_q      <= x2;
					end_y_q      <= y2;
					err_q        <= err_init;
					tdx_q        <= tdx_n;
					tdy_q        <= tdy_n;
					sxn_q        <= sxn_n;
					syn_q        <= syn_n;
					xm_q         <= xm_n;
					busy_q       <= !last_init;
					line_color_q <= pixel_color;
				end else if (busy_q) begin
					cur_x_q <= x_nx;
					cur_y_q <= y_nx;
					err_q   <= err_nx;
					busy_q  <= !last_nx;
				end
			end
			if (ctl.advance) begin
				valid_s1 <= ctl.accept && (is_start || busy_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			x_s1     <= is_start ? x1 : x_nx;
			y_s1     <= is_start ? y1 : y_nx;
			color_s1 <= is_start ? START_COLOR : line_color_q;
			last_s1  <= is_start ? last_init : last_nx;
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

/* rtl/bls_pix.sv */
// Clip test and framebuffer byte offset; result register (stage 2).
`timescale 1ns / 1ps
`default_nettype none
module bls_pix import bls_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic                  valid_s1,
	input  wire logic [COORD_BITS:0]   x_s1,
	input  wire logic [COORD_BITS:0]   y_s1,
	input  wire logic [COLOR_BITS-1:0] color_s1,
	input  wire logic                  last_s1,
	input  wire logic [CLIP_BITS-1:0]  clip_width,
	input  wire logic [CLIP_BITS-1:0]  clip_height,
	input  wire logic [PITCH_BITS-1:0] row_pitch_bytes,
	output logic                       out_valid,
	output logic [COORD_BITS-1:0]      pix_x,
	output logic [COORD_BITS-1:0]      pix_y,
	output logic [COLOR_BITS-1:0]      pix_color,
	output logic [OFF_BITS-1:0]        byte_offset,
	output logic                       visible,
	output logic                       last
);

	localparam int XW    = COORD_BITS + 1;
	localparam int CMP_W = XW + CLIP_BITS;

	logic              vis;
	logic [OFF_BITS-1:0] y_z, p_z, x2_z, off;

	assign vis = !x_s1[XW-1] && !y_s1[XW-1]
		&& ({{(CMP_W-XW){1'b0}}, x_s1} < {{(CMP_W-CLIP_BITS){1'b0}}, clip_width})
		&& ({{(CMP_W-XW){1'b0}}, y_s1} < {{(CMP_W-CLIP_BITS){1'b0}}, clip_height});

	// y*pitch + 2x, modulo 2^24; operands are non-negative whenever visible
	assign y_z  = {{(OFF_BITS-XW){1'b0}}, y_s1};
	assign p_z  = {{(OFF_BITS-PITCH_BITS){1'b0}}, row_pitch_bytes};
	assign x2_z = {{(OFF_BITS-XW-1){1'b0}}, x_s1, 1'b0};
	assign off  = vis ? (y_z * p_z + x2_z) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_x       <= x_s1[COORD_BITS-1:0];
			pix_y       <= y_s1[COORD_BITS-1:0];
			pix_color   <= color_s1;
			byte_offset <= off;
			visible     <= vis;
			last        <= last_s1;
		end
	end

endmodule
`default_nettype wire
